// ----- sv/motor_speed_pid_pwm_macros.svh -----
// assertion macros for the motor speed pid / pwm block
// used by the top level only; no other dependencies
`ifndef MOTOR_SPEED_PID_PWM_MACROS_SVH
`define MOTOR_SPEED_PID_PWM_MACROS_SVH
`ifndef SYNTH
`define MSPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define MSPP_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MSPP_ASSERT(lbl, prop)
`define MSPP_NEVER(lbl, cond)
`endif
`endif

// ----- sv/mspp_pkg.sv -----
// shared types, constants and helpers for the motor speed pid / pwm block
// no dependencies
package mspp_pkg;

    localparam int GAIN_FRAC_BITS = 16;

    localparam logic [23:0] SPEED_SCALE = 24'd15360000; // 60000 * 256
    localparam logic [9:0]  MS_PER_S    = 10'd1000;
    localparam logic [7:0]  DUTY_FULL   = 8'd255;
    localparam logic [15:0] DT_DEFAULT  = 16'd10;

    localparam logic [2:0] CFG_VOLTS = 3'd0;
    localparam logic [2:0] CFG_DIR   = 3'd1;
    localparam logic [2:0] CFG_GP    = 3'd2;
    localparam logic [2:0] CFG_GI    = 3'd3;
    localparam logic [2:0] CFG_GD    = 3'd4;
    localparam logic [2:0] CFG_STEPS = 3'd5;
    localparam logic [2:0] CFG_IVAL  = 3'd6;
    localparam logic [2:0] CFG_VMAX  = 3'd7;

    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    typedef struct packed {
        logic       start;
        logic       is_div;
        logic [5:0] n;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_stat;

    typedef enum logic [3:0] {
        S_NUM, S_DEN, S_SPD, S_ERRDT, S_ACCDIV, S_PMUL,
        S_IMUL, S_GDK, S_DMUL, S_DDIV, S_CMUL, S_CDIV
    } t_step;

    // floor(v * 255 / 24) via floor(floor(v*255/8) / 3), reciprocal 683/2048
    function automatic logic [8:0] f_setpoint(input logic [4:0] v);
        logic [12:0] x;
        logic [19:0] z;
        x = 13'(v) * 13'd255;
        z = 20'(x[12:3]) * 20'd683;
        return z[19:11];
    endfunction

endpackage

// ----- sv/mspp_serial_alu.sv -----
// bit-serial multiply / restoring divide unit, one bit per cycle
// depends on mspp_pkg
module mspp_serial_alu (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mspp_pkg::t_arith_req     i_req,
    input  logic [63:0]              i_opa,
    input  logic [63:0]              i_opb,
    output mspp_pkg::t_arith_stat    o_stat,
    output logic [63:0]              o_res
);
    import mspp_pkg::*;

    logic        r_busy, r_done, r_div;
    logic [5:0]  r_cnt;
    logic [63:0] r_a, r_b, r_acc;
    logic [31:0] r_rem;
    logic [32:0] w_trial, w_diff;
    logic        w_ge;

    // divide: divisor sits in r_a low bits, dividend shifts out of r_b top
    assign w_trial = {r_rem, r_b[63]};
    assign w_ge    = w_trial >= {1'b0, r_a[31:0]};
    assign w_diff  = w_trial - {1'b0, r_a[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_cnt  <= i_req.n;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_opa;
            r_b   <= i_opb;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_b   <= {r_b[62:0], w_ge};
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[62:0], 1'b0};
                r_b <= {1'b0, r_b[63:1]};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_div ? r_b : r_acc;

endmodule

// ----- sv/motor_speed_pid_pwm.sv -----
// motor speed pid controller: encoder count in, pwm duty and speed out
// depends on mspp_pkg, mspp_serial_alu and motor_speed_pid_pwm_macros.svh
//
// usage:
//  - input channel (i_in_valid / o_in_ready) carries one control tick: the
//    encoder pulse count and the ms elapsed since the last update
//  - output channel (o_out_valid / i_out_ready) returns one result per tick:
//    pwm duty, speed in rpm q16.8 and the direction pins
//  - configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//    the user must write it only while no tick is in flight; no check enforces it
//  - a tick runs twelve multiply / divide operations, one bit per cycle, through
//    a single shared serial unit, with a load and a wait state around each;
//    when the control value is not positive the last multiply and divide are
//    skipped
//  - one tick is worked at a time; the next one is taken once the result
//    sits in the output register, even while the receiver stalls it
//  - reset loads the register defaults and clears the integral and the
//    previous error
module motor_speed_pid_pwm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_pulse_count,
    input  logic [15:0] i_elapsed_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_pwm_duty,
    output logic [23:0] o_speed_rpm_q8,
    output logic        o_dir_a,
    output logic        o_dir_b,
    output logic        o_direction_invalid,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import mspp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    localparam int GF = GAIN_FRAC_BITS;

    t_state r_state;
    t_step  r_step;

    // configuration
    logic [4:0]  r_volts;
    logic [1:0]  r_dir;
    logic [23:0] r_gp, r_gi, r_gd;
    logic [15:0] r_steps, r_ival, r_vmax;

    // working registers
    logic [15:0]        r_count, r_dt;
    logic [39:0]        r_num;
    logic [31:0]        r_den;
    logic [23:0]        r_speed;
    logic signed [25:0] r_err, r_prior;
    logic [25:0]        r_eabs;
    logic signed [47:0] r_integ;
    logic [37:0]        r_q;
    logic [33:0]        r_gdk;
    logic [25:0]        r_dabs;
    logic               r_dneg;
    logic [58:0]        r_dprod;
    logic signed [49:0] r_ctrl;
    logic [7:0]         r_duty;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_o_duty;
    logic [23:0] r_o_speed;
    logic [1:0]  r_o_dir;

    t_arith_req  w_req;
    t_arith_stat w_stat;
    logic [63:0] w_opa, w_opb, w_res;

    logic [15:0]        w_steps, w_ival, w_vmax;
    logic [23:0]        w_speed_sat;
    logic signed [25:0] w_err;
    logic [47:0]        w_iabs;
    logic signed [48:0] w_isum;
    logic signed [47:0] w_isat;
    logic signed [26:0] w_diff;
    logic [32:0]        w_pmag;
    logic [45:0]        w_imag;
    logic [42:0]        w_dmag;
    logic               w_ctrl_nonpos;
    logic               w_in_acc, w_out_load;

    assign w_steps = (r_steps == 16'd0) ? 16'd1 : r_steps;
    assign w_ival  = (r_ival == 16'd0) ? 16'd1 : r_ival;
    assign w_vmax  = (r_vmax == 16'd0) ? 16'd1 : r_vmax;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == ST_OUT) && (!r_ovalid || i_out_ready);

    assign w_ctrl_nonpos = r_ctrl[49] || (r_ctrl == '0);
    assign w_iabs = r_integ[47] ? 48'(-r_integ) : 48'(r_integ);

    // post-processing of each unit result
    assign w_speed_sat = (w_res[39:24] != 16'd0) ? 24'hFFFFFF : w_res[23:0];
    assign w_err  = $signed({9'd0, f_setpoint(r_volts), 8'd0})
                  - $signed({2'd0, w_speed_sat});
    assign w_isum = $signed({r_integ[47], r_integ}) + $signed(w_res[48:0]);
    assign w_isat = (w_isum[48] != w_isum[47])
                  ? (w_isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                  : w_isum[47:0];
    assign w_diff = $signed({r_err[25], r_err}) - $signed({r_prior[25], r_prior});
    assign w_pmag = w_res[GF+32:GF];
    assign w_imag = w_res[GF+45:GF];
    assign w_dmag = w_res[GF+42:GF];

    // operand selection for the shared unit
    always_comb begin
        w_req.start  = (r_state == ST_LOAD) && !((r_step == S_CMUL) && w_ctrl_nonpos);
        w_req.is_div = 1'b0;
        w_req.n      = 6'd16;
        w_opa        = '0;
        w_opb        = '0;
        case (r_step)
            S_NUM: begin
                w_opa = 64'(SPEED_SCALE);
                w_opb = 64'(r_count);
            end
            S_DEN: begin
                w_opa = 64'(w_steps);
                w_opb = 64'(w_ival);
            end
            S_SPD: begin
                w_req.is_div = 1'b1;
                w_req.n      = 6'd40;
                w_opa        = 64'(r_den);
                w_opb        = {r_num, 24'd0};
            end
            S_ERRDT: begin
                // two's complement multiplicand gives the signed product
                w_opa = {{38{r_err[25]}}, r_err};
                w_opb = 64'(r_dt);
            end
            S_ACCDIV: begin
                w_req.is_div = 1'b1;
                w_req.n      = 6'd48;
                w_opa        = 64'(MS_PER_S);
                w_opb        = {w_iabs, 16'd0};
            end
            S_PMUL: begin
                w_req.n = 6'd24;
                w_opa   = 64'(r_eabs);
                w_opb   = 64'(r_gp);
            end
            S_IMUL: begin
                w_req.n = 6'd24;
                w_opa   = 64'(r_q);
                w_opb   = 64'(r_gi);
            end
            S_GDK: begin
                w_req.n = 6'd10;
                w_opa   = 64'(r_gd);
                w_opb   = 64'(MS_PER_S);
            end
            S_DMUL: begin
                w_req.n = 6'd26;
                w_opa   = 64'(r_gdk);
                w_opb   = 64'(r_dabs);
            end
            S_DDIV: begin
                w_req.is_div = 1'b1;
                w_req.n      = 6'd60;
                w_opa        = 64'(r_dt);
                w_opb        = {1'b0, r_dprod, 4'd0};
            end
            S_CMUL: begin
                w_req.n = 6'd8;
                w_opa   = 64'(r_ctrl[49:8]);
                w_opb   = 64'(DUTY_FULL);
            end
            S_CDIV: begin
                w_req.is_div = 1'b1;
                w_req.n      = 6'd48;
                w_opa        = 64'(w_vmax);
                w_opb        = {r_dprod[47:0], 16'd0};
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    mspp_serial_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volts <= 5'd0;
            r_dir   <= DIR_FWD;
            r_gp    <= 24'd119801;
            r_gi    <= 24'd1074889;
            r_gd    <= 24'd0;
            r_steps <= 16'd655;
            r_ival  <= 16'd50;
            r_vmax  <= 16'd232;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOLTS: r_volts <= i_cfg_data[4:0];
                CFG_DIR:   r_dir   <= i_cfg_data[1:0];
                CFG_GP:    r_gp    <= i_cfg_data;
                CFG_GI:    r_gi    <= i_cfg_data;
                CFG_GD:    r_gd    <= i_cfg_data;
                CFG_STEPS: r_steps <= i_cfg_data[15:0];
                CFG_IVAL:  r_ival  <= i_cfg_data[15:0];
                CFG_VMAX:  r_vmax  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= S_NUM;
            r_integ  <= '0;
            r_prior  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && !w_out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_step  <= S_NUM;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= ((r_step == S_CMUL) && w_ctrl_nonpos) ? ST_OUT : ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_stat.done) begin
                        if (r_step == S_ERRDT) begin
                            r_integ <= w_isat;
                        end
                        if (r_step == S_GDK) begin
                            r_prior <= r_err;
                        end
                        if (r_step == S_CDIV) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_step  <= t_step'(r_step + 4'd1);
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_count <= i_pulse_count;
            r_dt    <= (i_elapsed_ms == 16'd0) ? DT_DEFAULT : i_elapsed_ms;
        end
        if ((r_state == ST_LOAD) && (r_step == S_CMUL) && w_ctrl_nonpos) begin
            r_duty <= 8'd0;
        end
        if ((r_state == ST_WAIT) && w_stat.done) begin
            case (r_step)
                S_NUM: r_num <= w_res[39:0];
                S_DEN: r_den <= w_res[31:0];
                S_SPD: begin
                    r_speed <= w_speed_sat;
                    r_err   <= w_err;
                    r_eabs  <= w_err[25] ? 26'(-w_err) : 26'(w_err);
                end
                S_ACCDIV: r_q <= w_res[37:0];
                S_PMUL: begin
                    r_ctrl <= r_err[25] ? -$signed(50'(w_pmag)) : $signed(50'(w_pmag));
                end
                S_IMUL: begin
                    r_ctrl <= r_integ[47] ? r_ctrl - $signed(50'(w_imag))
                                          : r_ctrl + $signed(50'(w_imag));
                end
                S_GDK: begin
                    r_gdk  <= w_res[33:0];
                    r_dneg <= w_diff[26];
                    r_dabs <= w_diff[26] ? 26'(-w_diff) : 26'(w_diff);
                end
                S_DMUL: r_dprod <= w_res[58:0];
                S_DDIV: begin
                    r_ctrl <= r_dneg ? r_ctrl - $signed(50'(w_dmag))
                                     : r_ctrl + $signed(50'(w_dmag));
                end
                S_CMUL: r_dprod <= {11'd0, w_res[47:0]};
                S_CDIV: r_duty <= (w_res[63:8] != '0) ? DUTY_FULL : w_res[7:0];
                default: ;
            endcase
        end
        if (w_out_load) begin
            r_o_duty  <= r_duty;
            r_o_speed <= r_speed;
            r_o_dir   <= r_dir;
        end
    end

    assign o_in_ready          = (r_state == ST_IDLE);
    assign o_out_valid         = r_ovalid;
    assign o_pwm_duty          = r_o_duty;
    assign o_speed_rpm_q8      = r_o_speed;
    assign o_dir_a             = (r_o_dir == DIR_FWD);
    assign o_dir_b             = (r_o_dir == DIR_REV);
    assign o_direction_invalid = (r_o_dir != DIR_FWD) && (r_o_dir != DIR_REV);

`include "motor_speed_pid_pwm_macros.svh"

    // a new tick never enters while the serial unit still runs
    `MSPP_NEVER(a_no_accept_busy, o_in_ready && w_stat.busy)
    // the unit only finishes while the sequencer waits for it
    `MSPP_ASSERT(a_done_in_wait, w_stat.done |-> (r_state == ST_WAIT))
    // a negative control value always ends in zero duty
    `MSPP_ASSERT(a_neg_ctrl_zero, ((r_state == ST_OUT) && r_ctrl[49]) |-> (r_duty == 8'd0))

endmodule
